### rtl/assert_macros.svh
// assertion macros shared by the circle outline rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/circ_pkg.sv
// shared types, constants and the square root step for the circle outline generator
`default_nettype none

package circ_pkg;

    localparam logic [6:0] RADIUS_MAX = 7'd127;

    localparam int COORD_W = 10;
    localparam int SQ_W    = 15;
    localparam int D_W     = 8;
    localparam int SQ_STEPS = 7;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [1:0] FIRST_PHASE = 2'd0;
    localparam logic [1:0] LAST_PHASE  = 2'd3;

    localparam logic ACT_ALONG_X = 1'b0;

    // one request as it comes in
    typedef struct packed {
        logic              action;
        logic [7:0]        center_x;
        logic [7:0]        center_y;
        logic [6:0]        radius;
        logic signed [7:0] offset;
        logic [15:0]       color;
    } circ_in_t;

    // classified request handed from front to back
    typedef struct packed {
        logic              action;
        logic [7:0]        center_x;
        logic [7:0]        center_y;
        logic signed [7:0] offset;
        logic [15:0]       color;
        logic              clamped;
        logic [D_W-1:0]    half_chord;
    } circ_job_t;

    // one emitted pixel
    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic [15:0]               pixel_color;
        logic                      clamped;
        logic                      last;
    } circ_pix_t;

    // partial state of the digit-pair square root
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_state_t;

    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [SQ_W-1:0] bitv);
        sqrt_state_t     nx;
        logic [SQ_W-1:0] trial;
        trial = st.root + bitv;
        if (st.rem >= trial) begin
            nx.rem  = st.rem - trial;
            nx.root = (st.root >> 1) + bitv;
        end else begin
            nx.rem  = st.rem;
            nx.root = st.root >> 1;
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

### rtl/circ_front.sv
// front part: radius clamp, s = r*r - o*o and a two-stage rounded square root
`default_nettype none

`include "assert_macros.svh"

module circ_front import circ_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire circ_in_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output circ_job_t      out_job
);

    logic        v1_reg, v2_reg, v3_reg;
    circ_job_t   job1_reg, job2_reg, job3_reg;
    logic [SQ_W-1:0] sq1_reg;
    sqrt_state_t st2_reg;

    logic        advance;
    logic [6:0]  r_sat;
    logic [7:0]  mag;
    logic        clamp;
    logic [13:0] r_sq;
    logic [15:0] m_sq;
    logic [SQ_W-1:0] s_val;
    circ_job_t   job1_next;
    sqrt_state_t st2_next;
    sqrt_state_t st3_tmp;
    logic [D_W-1:0] dist_next;
    circ_job_t   job3_next;

    // whole pipe moves when the last stage is empty or being drained
    assign advance  = out_ready || !v3_reg;
    assign in_ready = advance;

    // stage 1: saturate radius, squares and difference
    always_comb begin
        r_sat = (in_item.radius > RADIUS_MAX) ? RADIUS_MAX : in_item.radius;
        mag   = in_item.offset[7] ? 8'(-in_item.offset) : 8'(in_item.offset);
        clamp = {1'b0, r_sat} < mag;
        r_sq  = 14'(r_sat) * 14'(r_sat);
        m_sq  = 16'(mag) * 16'(mag);
        s_val = clamp ? '0 : (SQ_W'(r_sq) - SQ_W'(m_sq));
        job1_next.action     = in_item.action;
        job1_next.center_x   = in_item.center_x;
        job1_next.center_y   = in_item.center_y;
        job1_next.offset     = in_item.offset;
        job1_next.color      = in_item.color;
        job1_next.clamped    = clamp;
        job1_next.half_chord = '0;
    end

    // stage 2: upper four root digits
    always_comb begin
        st2_next.rem  = sq1_reg;
        st2_next.root = '0;
        for (int k = SQ_STEPS - 1; k >= 3; k--) begin
            st2_next = sqrt_step(st2_next, SQ_W'(1) << (2 * k));
        end
    end

    // stage 3: lower three digits, then round to nearest
    always_comb begin
        st3_tmp = st2_reg;
        for (int k = 2; k >= 0; k--) begin
            st3_tmp = sqrt_step(st3_tmp, SQ_W'(1) << (2 * k));
        end
        dist_next = (st3_tmp.rem > st3_tmp.root) ? D_W'(st3_tmp.root + 1'b1)
                                                  : D_W'(st3_tmp.root);
        job3_next            = job2_reg;
        job3_next.half_chord = dist_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            job1_reg <= job1_next;
            sq1_reg  <= s_val;
            job2_reg <= job1_reg;
            st2_reg  <= st2_next;
            job3_reg <= job3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_job   = job3_reg;

    `ASSERT_IMPL(a_clamp_zero_dist, aclk, aresetn, v3_reg && job3_reg.clamped,
        job3_reg.half_chord == '0, "clamped request carries non-zero distance")

endmodule

`default_nettype wire

### rtl/circ_queue.sv
// short register queue between the front and back parts
`default_nettype none

`include "assert_macros.svh"

module circ_queue import circ_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire circ_job_t  in_job,
    output logic            out_valid,
    input  wire logic       out_ready,
    output circ_job_t       out_job
);

    circ_job_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign in_ready  = count_reg != QCNT_W'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

    `ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= QCNT_W'(QDEPTH), "queue fill above depth")
    `ASSERT_IMPL(a_ptr_match, aclk, aresetn, 1'b1,
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0],
        "queue pointers disagree with fill count")

endmodule

`default_nettype wire

### rtl/circ_back.sv
// back part: walks the four mirrored pixels of one request into an output register
`default_nettype none

`include "assert_macros.svh"

module circ_back import circ_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire circ_job_t  in_job,
    output logic            out_valid,
    input  wire logic       out_ready,
    output circ_pix_t       out_pix
);

    circ_job_t  job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    circ_pix_t  pix_reg;

    logic       load_out;
    logic       take;
    logic signed [COORD_W-1:0] cx, cy, o_ext, d_ext, a_term, b_term;
    circ_pix_t  pix_next;

    assign load_out = job_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !job_valid_reg || (load_out && phase_reg == LAST_PHASE);
    assign take     = in_valid && in_ready;

    always_comb begin
        cx    = COORD_W'(signed'({1'b0, job_reg.center_x}));
        cy    = COORD_W'(signed'({1'b0, job_reg.center_y}));
        o_ext = COORD_W'(job_reg.offset);
        d_ext = COORD_W'(signed'({1'b0, job_reg.half_chord}));
        // high phase bit mirrors the first axis, low bit the second
        if (job_reg.action == ACT_ALONG_X) begin
            a_term = phase_reg[1] ? -o_ext : o_ext;
            b_term = phase_reg[0] ? -d_ext : d_ext;
        end else begin
            a_term = phase_reg[1] ? -d_ext : d_ext;
            b_term = phase_reg[0] ? -o_ext : o_ext;
        end
        pix_next.pixel_x     = cx + a_term;
        pix_next.pixel_y     = cy + b_term;
        pix_next.pixel_color = job_reg.color;
        pix_next.clamped     = job_reg.clamped;
        pix_next.last        = phase_reg == LAST_PHASE;
    end

    always_comb begin
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
            phase_next     = phase_reg + 1'b1;
            if (phase_reg == LAST_PHASE) begin
                job_valid_next = 1'b0;
            end
        end
        if (take) begin
            job_valid_next = 1'b1;
            phase_next     = FIRST_PHASE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            phase_reg     <= FIRST_PHASE;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            job_reg <= in_job;
        end
        if (load_out) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = pix_reg;

    `ASSERT_NEXT(a_phase_wrap, aclk, aresetn, load_out && phase_reg == LAST_PHASE,
        phase_reg == FIRST_PHASE, "phase did not wrap after fourth pixel")

endmodule

`default_nettype wire

### rtl/circle_outline_pixel_gen.sv
// top level of the circle outline pixel generator: stream ports, front, queue and back
// path: the first pixel of a request passes three front stages, a queue slot and the back part's
//   job register to the output register; the other three follow back to back while m_tready stays high
// rate: the back part's four-pixel walk sets the sustained request rate;
//   the three-stage front and four-entry queue take short bursts back to back
// reset: synchronous, active low; clears valid bits, queue pointers and fill count, and the pixel phase only
`default_nettype none

module circle_outline_pixel_gen import circ_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // center_x[7:0], center_y[15:8], radius[22:16], offset[30:23], color[46:31], zero pad
    input  wire logic [47:0] s_tdata,
    // action[0]: 0 offset along x, 1 offset along y
    input  wire logic        s_tuser,
    // pixel channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_x[9:0], pixel_y[19:10], pixel_color[35:20], zero pad
    output logic [39:0]      m_tdata,
    // clamped[0]: offset magnitude was beyond the radius
    output logic             m_tuser,
    // fourth pixel of the request
    output logic             m_tlast
);

    circ_in_t  req;
    circ_job_t front_job, queue_job;
    circ_pix_t pix;
    logic      front_valid, front_ready;
    logic      queue_valid, queue_ready;

    // unpack the request fields
    always_comb begin
        req.action   = s_tuser;
        req.center_x = s_tdata[7:0];
        req.center_y = s_tdata[15:8];
        req.radius   = s_tdata[22:16];
        req.offset   = s_tdata[30:23];
        req.color    = s_tdata[46:31];
    end

    // front: clamp, squared distance and rounded root
    circ_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (req),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_job   (front_job)
    );

    // queue lets the front run ahead while the back walks pixels
    circ_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_job   (queue_job)
    );

    // back: four mirrored pixels per request, registered output
    circ_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_job    (queue_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (pix)
    );

    // pack the pixel fields
    assign m_tdata = {4'b0000, pix.pixel_color, pix.pixel_y, pix.pixel_x};
    assign m_tuser = pix.clamped;
    assign m_tlast = pix.last;

endmodule

`default_nettype wire
